/* rtl/core/jdm_pkg.sv */
// ----------------------------------------------------------------------------
// jdm_pkg
// Shared types and constants of the joystick differential mixer.
// ----------------------------------------------------------------------------
package jdm_pkg;

    localparam int LIMIT_BITS = 10;
    localparam int QUOT_BITS  = LIMIT_BITS + 1;
    localparam int OUT_BITS   = 20;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 5;

    // cos(pi/4) in Q24
    localparam int ROT_K_BITS = 24;
    localparam logic [ROT_K_BITS-1:0] ROT_K = 24'd11863283;

    localparam logic [LIMIT_BITS-1:0] DRIVE_LIMIT_RESET = 10'd255;

    typedef enum logic [2:0] {
        REG_X_LOW        = 3'd0,
        REG_X_HIGH       = 3'd1,
        REG_Y_LOW        = 3'd2,
        REG_Y_HIGH       = 3'd3,
        REG_DEAD_ZONE    = 3'd4,
        REG_DRIVE_LIMIT  = 3'd5,
        REG_MIXER_ENABLE = 3'd6
    } jdm_reg_t;

    typedef struct packed {
        logic valid;
        logic ok;
        logic x_zero;
        logic y_zero;
    } jdm_tag_t;

endpackage

/* rtl/core/jdm_divider.sv */
// ----------------------------------------------------------------------------
// jdm_divider
// Pipelined restoring divider, one quotient bit per stage. The numerator
// must satisfy num < den * 2**QUOT_BITS.
// ----------------------------------------------------------------------------
module jdm_divider #(
    parameter int DEN_BITS  = 12,
    parameter int QUOT_BITS = 11
) (
    input  logic                          clk,
    input  logic [DEN_BITS+QUOT_BITS-1:0] num,
    input  logic [DEN_BITS-1:0]           den,
    output logic [QUOT_BITS-1:0]          quot
);

    localparam int NUM_BITS = DEN_BITS + QUOT_BITS;

    logic [DEN_BITS-1:0]  rem_w [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] low_w [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] q_w   [QUOT_BITS+1];
    logic [DEN_BITS-1:0]  den_w [QUOT_BITS+1];

    assign rem_w[0] = num[NUM_BITS-1:QUOT_BITS];
    assign low_w[0] = num[QUOT_BITS-1:0];
    assign q_w[0]   = '0;
    assign den_w[0] = den;

    for (genvar s = 0; s < QUOT_BITS; s++)
    begin : g_stage
        logic [DEN_BITS:0]    trial;
        logic [DEN_BITS-1:0]  rem_next;
        logic [QUOT_BITS-1:0] q_next;
        logic [DEN_BITS-1:0]  rem_reg;
        logic [QUOT_BITS-1:0] low_reg;
        logic [QUOT_BITS-1:0] q_reg;
        logic [DEN_BITS-1:0]  den_reg;

        always_comb
        begin
            trial = {rem_w[s], low_w[s][QUOT_BITS-1]};
            if (trial >= {1'b0, den_w[s]})
            begin
                rem_next = DEN_BITS'(trial - {1'b0, den_w[s]});
                q_next   = {q_w[s][QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_BITS-1:0];
                q_next   = {q_w[s][QUOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_w[s][QUOT_BITS-2:0], 1'b0};
            q_reg   <= q_next;
            den_reg <= den_w[s];
        end

        assign rem_w[s+1] = rem_reg;
        assign low_w[s+1] = low_reg;
        assign q_w[s+1]   = q_reg;
        assign den_w[s+1] = den_reg;
    end

    assign quot = q_w[QUOT_BITS];

endmodule

/* rtl/core/joystick_differential_mixer.sv */
// ----------------------------------------------------------------------------
// joystick_differential_mixer
// Arcade-drive mixer: clamp, dead zone, linear map and 45 degree rotation of
// one joystick sample into left and right drive values.
// ----------------------------------------------------------------------------
// One item is taken every cycle; busy is always low. Results appear on
// done in order, one per item. The pipeline is the 11-stage range
// divider, one quotient bit per stage, plus five stages for shaping, the
// range multiply, the mix and the rotation multiply and rounding. The
// receiver cannot stall; nothing is held back.
// ----------------------------------------------------------------------------
module joystick_differential_mixer #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [SAMPLE_BITS-1:0]               stick_x,
    input  logic [SAMPLE_BITS-1:0]               stick_y,
    output logic                                 done,
    output logic                                 mix_ok,
    output logic signed [jdm_pkg::OUT_BITS-1:0]  left_drive,
    output logic signed [jdm_pkg::OUT_BITS-1:0]  right_drive,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [jdm_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [jdm_pkg::DATA_BITS-1:0]        pwdata,
    output logic [jdm_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready
);

    localparam int QB        = jdm_pkg::QUOT_BITS;
    localparam int LB        = jdm_pkg::LIMIT_BITS;
    localparam int OB        = jdm_pkg::OUT_BITS;
    localparam int NUM_BITS  = SAMPLE_BITS + QB;
    localparam int MAP_BITS  = QB + 1;
    localparam int PROD_BITS = QB + jdm_pkg::ROT_K_BITS;
    localparam int ROT_SHIFT = jdm_pkg::ROT_K_BITS - FRAC_BITS;
    localparam int DEPTH     = QB + 4;
    localparam int LAST      = DEPTH - 1;
    localparam logic [PROD_BITS:0] HALF = (PROD_BITS+1)'(1) << (ROT_SHIFT - 1);

    // configuration registers
    logic [SAMPLE_BITS-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg, dead_zone_reg;
    logic [LB-1:0]          drive_limit_reg;
    logic                   mixer_enable_reg;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg        <= '0;
            x_high_reg       <= '1;
            y_low_reg        <= '0;
            y_high_reg       <= '1;
            dead_zone_reg    <= '0;
            drive_limit_reg  <= jdm_pkg::DRIVE_LIMIT_RESET;
            mixer_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (jdm_pkg::jdm_reg_t'(paddr[4:2]))
                jdm_pkg::REG_X_LOW:        x_low_reg        <= pwdata[SAMPLE_BITS-1:0];
                jdm_pkg::REG_X_HIGH:       x_high_reg       <= pwdata[SAMPLE_BITS-1:0];
                jdm_pkg::REG_Y_LOW:        y_low_reg        <= pwdata[SAMPLE_BITS-1:0];
                jdm_pkg::REG_Y_HIGH:       y_high_reg       <= pwdata[SAMPLE_BITS-1:0];
                jdm_pkg::REG_DEAD_ZONE:    dead_zone_reg    <= pwdata[SAMPLE_BITS-1:0];
                jdm_pkg::REG_DRIVE_LIMIT:  drive_limit_reg  <= pwdata[LB-1:0];
                jdm_pkg::REG_MIXER_ENABLE: mixer_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (jdm_pkg::jdm_reg_t'(paddr[4:2]))
            jdm_pkg::REG_X_LOW:        prdata = jdm_pkg::DATA_BITS'(x_low_reg);
            jdm_pkg::REG_X_HIGH:       prdata = jdm_pkg::DATA_BITS'(x_high_reg);
            jdm_pkg::REG_Y_LOW:        prdata = jdm_pkg::DATA_BITS'(y_low_reg);
            jdm_pkg::REG_Y_HIGH:       prdata = jdm_pkg::DATA_BITS'(y_high_reg);
            jdm_pkg::REG_DEAD_ZONE:    prdata = jdm_pkg::DATA_BITS'(dead_zone_reg);
            jdm_pkg::REG_DRIVE_LIMIT:  prdata = jdm_pkg::DATA_BITS'(drive_limit_reg);
            jdm_pkg::REG_MIXER_ENABLE: prdata = jdm_pkg::DATA_BITS'(mixer_enable_reg);
            default:                   prdata = '0;
        endcase
    end

    // clamp, dead zone snap, offset from range low
    function automatic logic [SAMPLE_BITS-1:0] axis_offset(
        input logic [SAMPLE_BITS-1:0] v,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi,
        input logic [SAMPLE_BITS-1:0] dz
    );
        logic [SAMPLE_BITS-1:0] c;
        logic [SAMPLE_BITS-1:0] mid;
        logic [SAMPLE_BITS-1:0] gap;
        c    = (v < lo) ? lo : v;
        c    = (c > hi) ? hi : c;
        mid  = lo + ((hi - lo) >> 1);
        gap  = (c >= mid) ? (c - mid) : (mid - c);
        if (gap <= dz)
            c = mid;
        return c - lo;
    endfunction

    // sideband travels with the data
    jdm_pkg::jdm_tag_t tag_reg  [DEPTH];
    jdm_pkg::jdm_tag_t tag_next;

    always_comb
    begin
        tag_next.valid  = start && !busy;
        tag_next.ok     = mixer_enable_reg && (x_low_reg <= x_high_reg)
                          && (y_low_reg <= y_high_reg);
        tag_next.x_zero = (x_low_reg == x_high_reg);
        tag_next.y_zero = (y_low_reg == y_high_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_next;
            for (int i = 1; i < DEPTH; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    // stage 1: axis shaping
    logic [SAMPLE_BITS-1:0] off_x_reg, off_y_reg;

    always_ff @(posedge clk)
    begin
        off_x_reg <= axis_offset(stick_x, x_low_reg, x_high_reg, dead_zone_reg);
        off_y_reg <= axis_offset(stick_y, y_low_reg, y_high_reg, dead_zone_reg);
    end

    // stage 2: scale by twice the drive limit
    logic [NUM_BITS-1:0] num_x_reg, num_y_reg;
    logic [NUM_BITS-1:0] span_next;

    assign span_next = NUM_BITS'({drive_limit_reg, 1'b0});

    always_ff @(posedge clk)
    begin
        num_x_reg <= NUM_BITS'(off_x_reg) * span_next;
        num_y_reg <= NUM_BITS'(off_y_reg) * span_next;
    end

    // divide by range width
    logic [QB-1:0] quot_x, quot_y;

    jdm_divider #(
        .DEN_BITS  (SAMPLE_BITS),
        .QUOT_BITS (QB)
    ) u_div_x (
        .clk  (clk),
        .num  (num_x_reg),
        .den  (x_high_reg - x_low_reg),
        .quot (quot_x)
    );

    jdm_divider #(
        .DEN_BITS  (SAMPLE_BITS),
        .QUOT_BITS (QB)
    ) u_div_y (
        .clk  (clk),
        .num  (num_y_reg),
        .den  (y_high_reg - y_low_reg),
        .quot (quot_y)
    );

    // stage 4: center, mix, sign-magnitude
    logic signed [MAP_BITS-1:0] map_x, map_y, sum_next, diff_next;
    logic                       sum_neg_reg, diff_neg_reg;
    logic [QB-1:0]              sum_mag_reg, diff_mag_reg;

    always_comb
    begin
        map_x = tag_reg[QB+1].x_zero ? '0
              : $signed({1'b0, quot_x}) - $signed({2'b00, drive_limit_reg});
        map_y = tag_reg[QB+1].y_zero ? '0
              : $signed({1'b0, quot_y}) - $signed({2'b00, drive_limit_reg});
        sum_next  = map_y + map_x;
        diff_next = map_y - map_x;
    end

    always_ff @(posedge clk)
    begin
        sum_neg_reg  <= sum_next[MAP_BITS-1];
        diff_neg_reg <= diff_next[MAP_BITS-1];
        sum_mag_reg  <= QB'(sum_next[MAP_BITS-1] ? -sum_next : sum_next);
        diff_mag_reg <= QB'(diff_next[MAP_BITS-1] ? -diff_next : diff_next);
    end

    // stage 5: rotation multiply
    logic [PROD_BITS-1:0] sum_prod_reg, diff_prod_reg;
    logic                 sum_neg_d_reg, diff_neg_d_reg;

    always_ff @(posedge clk)
    begin
        sum_prod_reg   <= PROD_BITS'(sum_mag_reg) * PROD_BITS'(jdm_pkg::ROT_K);
        diff_prod_reg  <= PROD_BITS'(diff_mag_reg) * PROD_BITS'(jdm_pkg::ROT_K);
        sum_neg_d_reg  <= sum_neg_reg;
        diff_neg_d_reg <= diff_neg_reg;
    end

    // stage 6: round half away from zero, restore sign
    logic [PROD_BITS:0] sum_rnd, diff_rnd;
    logic [OB-1:0]      left_next, right_next;

    always_comb
    begin
        sum_rnd  = ({1'b0, sum_prod_reg} + HALF) >> ROT_SHIFT;
        diff_rnd = ({1'b0, diff_prod_reg} + HALF) >> ROT_SHIFT;
        left_next  = sum_neg_d_reg  ? OB'(-sum_rnd[OB-1:0])  : sum_rnd[OB-1:0];
        right_next = diff_neg_d_reg ? OB'(-diff_rnd[OB-1:0]) : diff_rnd[OB-1:0];
        if (!tag_reg[LAST].ok)
        begin
            left_next  = '0;
            right_next = '0;
        end
    end

    logic          done_reg, mix_ok_reg;
    logic [OB-1:0] left_reg, right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            mix_ok_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= tag_reg[LAST].valid;
            mix_ok_reg <= tag_reg[LAST].valid && tag_reg[LAST].ok;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign done        = done_reg;
    assign mix_ok      = mix_ok_reg;
    assign left_drive  = $signed(left_reg);
    assign right_drive = $signed(right_reg);

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##(DEPTH) done)
        else $error("item did not complete at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(tag_reg[LAST].valid))
        else $error("result without an item");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        mix_ok |-> done)
        else $error("mix_ok outside a result");

    a_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !mix_ok) |-> (left_drive == '0 && right_drive == '0))
        else $error("nonzero drive without mixing");

endmodule
